// ----- hw/rtl/wcrf_pkg.sv -----
// ----------------------------------------------------------------------------
// wcrf_pkg
// Shared types, widths and the quarter-wave cosine table function of the
// warmup / cosine restart factor pipeline.
// ----------------------------------------------------------------------------
package wcrf_pkg;

	localparam int FRAC_BITS       = 24;
	localparam int COS_TABLE_DEPTH = 1024;

	localparam int EPOCH_W = 32;
	localparam int CYC_W   = 16;
	localparam int RATE_W  = 32;
	localparam int SCALE_W = 25;
	localparam int SEG_W   = 2;

	localparam int TAB_AW  = $clog2(COS_TABLE_DEPTH) + 1;
	localparam int IDX_W   = $clog2(2 * COS_TABLE_DEPTH) + 1;
	localparam int TAB_W   = 31;
	localparam int H_W     = 31;
	localparam int QUOT_W  = FRAC_BITS + 1;

	localparam logic [63:0] Q30_ONE     = 64'd1073741824;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	typedef enum logic [1:0] {
		SEG_WARMUP = 2'd0,
		SEG_DECAY  = 2'd1,
		SEG_FLAT   = 2'd2
	} seg_t;

	typedef enum logic [1:0] {
		REG_WARMUP = 2'd0,
		REG_BASE   = 2'd1,
		REG_FLOOR  = 2'd2,
		REG_CYCLE  = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [CYC_W-1:0]  warmup;
		logic [CYC_W-1:0]  cyc;
		logic [CYC_W-1:0]  decay;
		logic [RATE_W-1:0] base;
		logic [RATE_W-1:0] flo;
		logic [RATE_W-1:0] span;
	} cfg_t;

	// cos(k*pi/(2*depth)) in Q30, Horner form of the Taylor series to x^12
	function automatic logic [TAB_W-1:0] cos_entry(input int unsigned k);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] p;
		x = (HALF_PI_Q30 * 64'(k) + 64'(COS_TABLE_DEPTH / 2)) / 64'(COS_TABLE_DEPTH);
		x2 = (x * x) >> 30;
		t = Q30_ONE;
		p = ((x2 * t) >> 30) / 64'd132;
		t = (p >= Q30_ONE) ? 64'd0 : Q30_ONE - p;
		p = ((x2 * t) >> 30) / 64'd90;
		t = (p >= Q30_ONE) ? 64'd0 : Q30_ONE - p;
		p = ((x2 * t) >> 30) / 64'd56;
		t = (p >= Q30_ONE) ? 64'd0 : Q30_ONE - p;
		p = ((x2 * t) >> 30) / 64'd30;
		t = (p >= Q30_ONE) ? 64'd0 : Q30_ONE - p;
		p = ((x2 * t) >> 30) / 64'd12;
		t = (p >= Q30_ONE) ? 64'd0 : Q30_ONE - p;
		p = ((x2 * t) >> 30) / 64'd2;
		t = (p >= Q30_ONE) ? 64'd0 : Q30_ONE - p;
		if (k >= COS_TABLE_DEPTH) begin
			t = 64'd0;
		end
		return t[TAB_W-1:0];
	endfunction

endpackage

// ----- hw/rtl/wcrf_req_if.sv -----
// ----------------------------------------------------------------------------
// wcrf_req_if
// Request channel: one epoch number per transfer.
// ----------------------------------------------------------------------------
interface wcrf_req_if;
	import wcrf_pkg::*;

	logic               valid;
	logic               ready;
	logic [EPOCH_W-1:0] epoch_number;

	modport source (output valid, output epoch_number, input ready);
	modport sink (input valid, input epoch_number, output ready);
endinterface

// ----- hw/rtl/wcrf_rsp_if.sv -----
// ----------------------------------------------------------------------------
// wcrf_rsp_if
// Response channel: scale factor and segment per transfer.
// ----------------------------------------------------------------------------
interface wcrf_rsp_if;
	import wcrf_pkg::*;

	logic               valid;
	logic               ready;
	logic [SCALE_W-1:0] scale_factor;
	logic [SEG_W-1:0]   segment;

	modport source (output valid, output scale_factor, output segment, input ready);
	modport sink (input valid, input scale_factor, input segment, output ready);
endinterface

// ----- hw/rtl/wcrf_phase.sv -----
// ----------------------------------------------------------------------------
// wcrf_phase
// Cycle position by a radix-2 pipelined remainder, then the rounded table
// phase index by a second pipelined divider, two bits per stage.
// ----------------------------------------------------------------------------
module wcrf_phase (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      adv,
	input  wcrf_pkg::cfg_t            cfg,
	input  logic                      in_valid,
	input  logic [wcrf_pkg::EPOCH_W-1:0] epoch,
	output logic                      out_valid,
	output logic [wcrf_pkg::IDX_W-1:0]   idx,
	output wcrf_pkg::seg_t            seg
);
	import wcrf_pkg::*;

	localparam int MOD_STG = (EPOCH_W + 1) / 2;
	localparam int IDX_STG = (IDX_W + 1) / 2;
	localparam int N_W     = CYC_W + IDX_W;

	logic               mv_s    [MOD_STG+1];
	logic               mwarm_s [MOD_STG+1];
	logic [CYC_W-1:0]   mrem_s  [MOD_STG+1];
	logic [EPOCH_W-1:0] moff_s  [MOD_STG+1];
	logic [CYC_W-1:0]   mrem_n  [MOD_STG];
	logic [EPOCH_W-1:0] moff_n  [MOD_STG];

	logic               xv_s    [IDX_STG+1];
	seg_t               xseg_s  [IDX_STG+1];
	logic [CYC_W-1:0]   xrem_s  [IDX_STG+1];
	logic [IDX_W-1:0]   xlow_s  [IDX_STG+1];
	logic [CYC_W-1:0]   xrem_n  [IDX_STG];
	logic [IDX_W-1:0]   xlow_n  [IDX_STG];

	logic [CYC_W-1:0]   pos;
	logic [N_W-1:0]     num;
	seg_t               seg_in;

	// remainder steps
	always_comb begin
		logic [CYC_W-1:0]   r;
		logic [EPOCH_W-1:0] o;
		logic [CYC_W:0]     t;
		for (int k = 0; k < MOD_STG; k++) begin
			r = mrem_s[k];
			o = moff_s[k];
			for (int j = 0; j < 2; j++) begin
				if (k * 2 + j < EPOCH_W) begin
					t = {r, o[EPOCH_W-1]};
					if (t >= {1'b0, cfg.cyc}) begin
						t = t - {1'b0, cfg.cyc};
					end
					r = t[CYC_W-1:0];
					o = {o[EPOCH_W-2:0], 1'b0};
				end
			end
			mrem_n[k] = r;
			moff_n[k] = o;
		end
	end

	// index division steps, quotient shifts into the low word
	always_comb begin
		logic [CYC_W-1:0] r;
		logic [IDX_W-1:0] l;
		logic [CYC_W:0]   t;
		logic             q;
		for (int k = 0; k < IDX_STG; k++) begin
			r = xrem_s[k];
			l = xlow_s[k];
			for (int j = 0; j < 2; j++) begin
				if (k * 2 + j < IDX_W) begin
					t = {r, l[IDX_W-1]};
					q = (t >= {1'b0, cfg.decay});
					if (q) begin
						t = t - {1'b0, cfg.decay};
					end
					r = t[CYC_W-1:0];
					l = {l[IDX_W-2:0], q};
				end
			end
			xrem_n[k] = r;
			xlow_n[k] = l;
		end
	end

	assign pos = mrem_s[MOD_STG];
	assign num = (N_W'(pos) << (IDX_W - 1)) + N_W'(cfg.decay >> 1);

	always_comb begin
		if (mwarm_s[MOD_STG]) begin
			seg_in = SEG_WARMUP;
		end else if (pos >= cfg.decay) begin
			seg_in = SEG_FLAT;
		end else begin
			seg_in = SEG_DECAY;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= MOD_STG; k++) begin
				mv_s[k] <= 1'b0;
			end
			for (int k = 0; k <= IDX_STG; k++) begin
				xv_s[k] <= 1'b0;
			end
		end else if (adv) begin
			mv_s[0] <= in_valid;
			for (int k = 0; k < MOD_STG; k++) begin
				mv_s[k+1] <= mv_s[k];
			end
			xv_s[0] <= mv_s[MOD_STG];
			for (int k = 0; k < IDX_STG; k++) begin
				xv_s[k+1] <= xv_s[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mwarm_s[0] <= (epoch < EPOCH_W'(cfg.warmup));
			mrem_s[0]  <= '0;
			moff_s[0]  <= epoch - EPOCH_W'(cfg.warmup);
			for (int k = 0; k < MOD_STG; k++) begin
				mwarm_s[k+1] <= mwarm_s[k];
				mrem_s[k+1]  <= mrem_n[k];
				moff_s[k+1]  <= moff_n[k];
			end
			xseg_s[0] <= seg_in;
			xrem_s[0] <= num[N_W-1:IDX_W];
			xlow_s[0] <= num[IDX_W-1:0];
			for (int k = 0; k < IDX_STG; k++) begin
				xseg_s[k+1] <= xseg_s[k];
				xrem_s[k+1] <= xrem_n[k];
				xlow_s[k+1] <= xlow_n[k];
			end
		end
	end

	assign out_valid = xv_s[IDX_STG];
	assign idx       = xlow_s[IDX_STG];
	assign seg       = xseg_s[IDX_STG];

endmodule

// ----- hw/rtl/wcrf_cos.sv -----
// ----------------------------------------------------------------------------
// wcrf_cos
// Quarter-wave table lookup with symmetry fold, registered table read and
// the half-cosine term (1 + cos) / 2 in Q30, zero outside the decay segment.
// ----------------------------------------------------------------------------
module wcrf_cos (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       adv,
	input  logic                       in_valid,
	input  logic [wcrf_pkg::IDX_W-1:0] idx,
	input  wcrf_pkg::seg_t             in_seg,
	output logic                       out_valid,
	output logic [wcrf_pkg::H_W-1:0]   h,
	output wcrf_pkg::seg_t             out_seg
);
	import wcrf_pkg::*;

	localparam logic [IDX_W-1:0] TWO_D = IDX_W'(2 * COS_TABLE_DEPTH);
	localparam logic [IDX_W-1:0] ONE_D = IDX_W'(COS_TABLE_DEPTH);

	logic [TAB_W-1:0]  rom_w [COS_TABLE_DEPTH+1];

	logic              v_s1;
	logic              v_s2;
	logic              v_s3;
	logic [TAB_AW-1:0] addr_s1;
	logic              neg_s1;
	logic              neg_s2;
	seg_t              seg_s1;
	seg_t              seg_s2;
	seg_t              seg_s3;
	logic [TAB_W-1:0]  c_s2;
	logic [H_W-1:0]    h_s3;

	logic [IDX_W-1:0]  idx_c;
	logic [IDX_W-1:0]  fold;
	logic [TAB_W:0]    hsum;

	for (genvar k = 0; k <= COS_TABLE_DEPTH; k++) begin : g_rom
		assign rom_w[k] = cos_entry(k);
	end

	assign idx_c = (idx > TWO_D) ? TWO_D : idx;
	assign fold  = (idx_c < ONE_D) ? idx_c : TWO_D - idx_c;

	always_comb begin
		if (neg_s2) begin
			hsum = (TAB_W+1)'(Q30_ONE) - {1'b0, c_s2};
		end else begin
			hsum = (TAB_W+1)'(Q30_ONE) + {1'b0, c_s2};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			addr_s1 <= fold[TAB_AW-1:0];
			neg_s1  <= (idx_c >= ONE_D);
			seg_s1  <= in_seg;
			c_s2    <= rom_w[addr_s1];
			neg_s2  <= neg_s1;
			seg_s2  <= seg_s1;
			h_s3    <= (seg_s2 == SEG_DECAY) ? hsum[TAB_W:1] : '0;
			seg_s3  <= seg_s2;
		end
	end

	assign out_valid = v_s3;
	assign h         = h_s3;
	assign out_seg   = seg_s3;

endmodule

// ----- hw/rtl/wcrf_factor.sv -----
// ----------------------------------------------------------------------------
// wcrf_factor
// Numerator floor*2^30 + span*h, then a radix-2 pipelined divide by the
// base rate, two quotient bits per stage; the warmup segment gives one.
// ----------------------------------------------------------------------------
module wcrf_factor (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         adv,
	input  wcrf_pkg::cfg_t               cfg,
	input  logic                         in_valid,
	input  logic [wcrf_pkg::H_W-1:0]     h,
	input  wcrf_pkg::seg_t               in_seg,
	output logic                         out_valid,
	output logic [wcrf_pkg::SCALE_W-1:0] scale,
	output wcrf_pkg::seg_t               out_seg
);
	import wcrf_pkg::*;

	localparam int PROD_W = RATE_W + H_W;
	localparam int NUM_W  = RATE_W + 31;
	localparam int SH     = 30 - FRAC_BITS;
	localparam int DIV_STG = (QUOT_W + 1) / 2;

	logic              pv_s1;
	seg_t              pseg_s1;
	logic [PROD_W-1:0] prod_s1;

	logic              dv_s    [DIV_STG+1];
	seg_t              dseg_s  [DIV_STG+1];
	logic [RATE_W-1:0] drem_s  [DIV_STG+1];
	logic [QUOT_W-1:0] dlow_s  [DIV_STG+1];
	logic [RATE_W-1:0] drem_n  [DIV_STG];
	logic [QUOT_W-1:0] dlow_n  [DIV_STG];

	logic [NUM_W-1:0]  num;

	assign num = (NUM_W'(cfg.flo) << 30) + NUM_W'(prod_s1);

	always_comb begin
		logic [RATE_W-1:0] r;
		logic [QUOT_W-1:0] l;
		logic [RATE_W:0]   t;
		logic              q;
		for (int k = 0; k < DIV_STG; k++) begin
			r = drem_s[k];
			l = dlow_s[k];
			for (int j = 0; j < 2; j++) begin
				if (k * 2 + j < QUOT_W) begin
					t = {r, l[QUOT_W-1]};
					q = (t >= {1'b0, cfg.base});
					if (q) begin
						t = t - {1'b0, cfg.base};
					end
					r = t[RATE_W-1:0];
					l = {l[QUOT_W-2:0], q};
				end
			end
			drem_n[k] = r;
			dlow_n[k] = l;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_s1 <= 1'b0;
			for (int k = 0; k <= DIV_STG; k++) begin
				dv_s[k] <= 1'b0;
			end
		end else if (adv) begin
			pv_s1   <= in_valid;
			dv_s[0] <= pv_s1;
			for (int k = 0; k < DIV_STG; k++) begin
				dv_s[k+1] <= dv_s[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s1   <= PROD_W'(cfg.span) * PROD_W'(h);
			pseg_s1   <= in_seg;
			dseg_s[0] <= pseg_s1;
			drem_s[0] <= RATE_W'(num >> (SH + QUOT_W));
			dlow_s[0] <= QUOT_W'(num >> SH);
			for (int k = 0; k < DIV_STG; k++) begin
				dseg_s[k+1] <= dseg_s[k];
				drem_s[k+1] <= drem_n[k];
				dlow_s[k+1] <= dlow_n[k];
			end
		end
	end

	assign out_valid = dv_s[DIV_STG];
	assign out_seg   = dseg_s[DIV_STG];
	assign scale     = (dseg_s[DIV_STG] == SEG_WARMUP) ?
		SCALE_W'(1 << FRAC_BITS) : SCALE_W'(dlow_s[DIV_STG]);

endmodule

// ----- hw/rtl/warmup_cosine_restart_factor.sv -----
// ----------------------------------------------------------------------------
// warmup_cosine_restart_factor
// Path: wcrf_phase, then wcrf_cos, then wcrf_factor, from request to response.
// Throughput: one epoch per cycle; the whole pipeline holds while the
// response is stalled.
// Reset: arst_n clears all valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
module warmup_cosine_restart_factor (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	wcrf_req_if.sink    req,
	wcrf_rsp_if.source  rsp
);
	import wcrf_pkg::*;

	logic [CYC_W-1:0]  warmup_q;
	logic [RATE_W-1:0] base_q;
	logic [RATE_W-1:0] floor_q;
	logic [CYC_W-1:0]  cycle_q;

	cfg_t              cfg;
	logic              adv;
	logic              wr_en;

	logic              ph_valid;
	logic [IDX_W-1:0]  ph_idx;
	seg_t              ph_seg;
	logic              cs_valid;
	logic [H_W-1:0]    cs_h;
	seg_t              cs_seg;
	logic              fc_valid;
	logic [SCALE_W-1:0] fc_scale;
	seg_t              fc_seg;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			warmup_q <= '0;
			base_q   <= 32'd4294967;
			floor_q  <= '0;
			cycle_q  <= 16'd1;
		end else if (wr_en) begin
			case (reg_idx_t'(paddr[3:2]))
				REG_WARMUP: warmup_q <= pwdata[CYC_W-1:0];
				REG_BASE:   base_q   <= pwdata;
				REG_FLOOR:  floor_q  <= pwdata;
				REG_CYCLE:  cycle_q  <= pwdata[CYC_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx_t'(paddr[3:2]))
			REG_WARMUP: prdata = 32'(warmup_q);
			REG_BASE:   prdata = base_q;
			REG_FLOOR:  prdata = floor_q;
			REG_CYCLE:  prdata = 32'(cycle_q);
			default:    prdata = '0;
		endcase
	end

	// effective register values
	always_comb begin
		cfg.warmup = warmup_q;
		cfg.base   = (base_q == '0) ? RATE_W'(1) : base_q;
		cfg.flo    = (floor_q > cfg.base) ? cfg.base : floor_q;
		cfg.cyc    = (cycle_q == '0) ? CYC_W'(1) : cycle_q;
		cfg.decay  = (cfg.cyc > warmup_q) ? cfg.cyc - warmup_q : CYC_W'(1);
		cfg.span   = cfg.base - cfg.flo;
	end

	assign adv       = !fc_valid || rsp.ready;
	assign req.ready = adv;

	wcrf_phase u_phase (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.cfg       (cfg),
		.in_valid  (req.valid),
		.epoch     (req.epoch_number),
		.out_valid (ph_valid),
		.idx       (ph_idx),
		.seg       (ph_seg)
	);

	wcrf_cos u_cos (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (ph_valid),
		.idx       (ph_idx),
		.in_seg    (ph_seg),
		.out_valid (cs_valid),
		.h         (cs_h),
		.out_seg   (cs_seg)
	);

	wcrf_factor u_factor (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.cfg       (cfg),
		.in_valid  (cs_valid),
		.h         (cs_h),
		.in_seg    (cs_seg),
		.out_valid (fc_valid),
		.scale     (fc_scale),
		.out_seg   (fc_seg)
	);

	assign rsp.valid        = fc_valid;
	assign rsp.scale_factor = fc_scale;
	assign rsp.segment      = SEG_W'(fc_seg);

	a_seg_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> rsp.segment <= SEG_FLAT)
		else $error("bad segment code");

	a_warm_one: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.segment == SEG_WARMUP) |-> rsp.scale_factor == SCALE_W'(1 << FRAC_BITS))
		else $error("warmup factor not one");

	a_max_one: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> rsp.scale_factor <= SCALE_W'(1 << FRAC_BITS))
		else $error("factor above one");

endmodule

// ----- tb/sv/warmup_cosine_restart_factor_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// warmup_cosine_restart_factor_test
// Drives epoch queries through the restart factor pipeline under several
// register settings and idle patterns, and compares each response with a
// local fixed-point predictor of the warmup / cosine / flat schedule.
// ----------------------------------------------------------------------------
module warmup_cosine_restart_factor_test;
	import wcrf_pkg::*;

	typedef struct packed {
		logic [SCALE_W-1:0] scale;
		seg_t               seg;
	} factor_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	wcrf_req_if req ();
	wcrf_rsp_if rsp ();

	warmup_cosine_restart_factor i_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.req(req.sink), .rsp(rsp.source)
	);

	logic [63:0] cos_q30_tab [0:COS_TABLE_DEPTH];
	logic [63:0] warmup_reg, base_reg, floor_reg, cycle_reg;
	logic [31:0] epoch_queue [$];
	factor_t     factor_queue [$];
	int          send_idle_pct, recv_stall_pct;
	int          fail_count;
	logic        req_taken;

	initial begin
		clk = 1'b0;
	end
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic logic [63:0] taylor_cos(input logic [63:0] x);
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] p;
		x2 = (x * x) >> 30;
		t = Q30_ONE;
		for (int n = 6; n >= 1; n--) begin
			p = ((x2 * t) >> 30) / 64'((2 * n) * (2 * n - 1));
			t = (p >= Q30_ONE) ? 64'd0 : Q30_ONE - p;
		end
		return t;
	endfunction

	function automatic factor_t predict_factor(input logic [31:0] epoch);
		logic [63:0] base, flo, cyc, decay, pos, h, num, den, idx, two_d;
		factor_t f;
		two_d = 64'(2 * COS_TABLE_DEPTH);
		base = (base_reg != 0) ? base_reg : 64'd1;
		flo = (floor_reg > base) ? base : floor_reg;
		cyc = (cycle_reg != 0) ? cycle_reg : 64'd1;
		decay = (cyc > warmup_reg) ? cyc - warmup_reg : 64'd1;
		if (64'(epoch) < warmup_reg) begin
			f.scale = SCALE_W'(64'd1 << FRAC_BITS);
			f.seg = SEG_WARMUP;
		end else begin
			pos = (64'(epoch) - warmup_reg) % cyc;
			if (pos >= decay) begin
				h = 0;
				f.seg = SEG_FLAT;
			end else begin
				idx = (pos * two_d + decay / 2) / decay;
				if (idx > two_d) begin
					idx = two_d;
				end
				if (idx < COS_TABLE_DEPTH) begin
					h = (Q30_ONE + cos_q30_tab[idx]) >> 1;
				end else begin
					h = (Q30_ONE - cos_q30_tab[two_d - idx]) >> 1;
				end
				f.seg = SEG_DECAY;
			end
			num = (flo << 30) + (base - flo) * h;
			den = base << (30 - FRAC_BITS);
			f.scale = SCALE_W'(num / den);
		end
		return f;
	endfunction

	task automatic report_mismatch(input string what);
		$display("mismatch: %s", what);
		fail_count++;
	endtask

	task automatic add_epoch(input logic [31:0] e);
		epoch_queue = {epoch_queue, e};
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 4'(idx) << 2;
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_WARMUP: warmup_reg = 64'(value[15:0]);
			REG_BASE:   base_reg = 64'(value);
			REG_FLOOR:  floor_reg = 64'(value);
			REG_CYCLE:  cycle_reg = 64'(value[15:0]);
			default: ;
		endcase
	endtask

	task automatic drain();
		while (epoch_queue.size() != 0 || factor_queue.size() != 0) begin
			@(negedge clk);
		end
		repeat (50) @(negedge clk);
	endtask

	task automatic set_regs(input logic [31:0] w, b, f, c);
		drain();
		write_reg(REG_WARMUP, w);
		write_reg(REG_BASE, b);
		write_reg(REG_FLOOR, f);
		write_reg(REG_CYCLE, c);
	endtask

	function automatic logic [31:0] pick_epoch();
		logic [63:0] span;
		span = warmup_reg + 3 * ((cycle_reg != 0) ? cycle_reg : 64'd1);
		case ($urandom_range(0, 9))
			0:       return $urandom;
			1:       return 32'hFFFF_FFFF - $urandom_range(0, 70000);
			default: return 32'($urandom_range(0, 32'(span)));
		endcase
	endfunction

	task automatic run_random(input int count);
		for (int n = 0; n < count; n++) begin
			add_epoch(pick_epoch());
		end
	endtask

	// driver
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.epoch_number <= '0;
			req_taken = 1'b0;
		end else if (!req.valid || req_taken) begin
			req_taken = 1'b0;
			if (epoch_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				req.valid <= 1'b1;
				req.epoch_number <= epoch_queue[0];
			end else begin
				req.valid <= 1'b0;
			end
		end
		rsp.ready <= arst_n && ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// monitor
	always @(posedge clk) begin
		factor_t got;
		factor_t want;
		if (arst_n && req.valid && req.ready) begin
			factor_queue = {factor_queue, predict_factor(req.epoch_number)};
			void'(epoch_queue.pop_front());
			req_taken = 1'b1;
		end
		if (arst_n && rsp.valid && rsp.ready) begin
			got.scale = rsp.scale_factor;
			got.seg = seg_t'(rsp.segment);
			if (factor_queue.size() == 0) begin
				report_mismatch("response with nothing expected");
			end else begin
				want = factor_queue.pop_front();
				if (got.scale !== want.scale) begin
					report_mismatch($sformatf("scale_factor %0d, expected %0d",
						got.scale, want.scale));
				end
				if (got.seg !== want.seg) begin
					report_mismatch($sformatf("segment %0d, expected %0d",
						got.seg, want.seg));
				end
			end
		end
	end

	initial begin
		#20_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		logic [63:0] x;
		for (int k = 0; k < COS_TABLE_DEPTH; k++) begin
			x = (HALF_PI_Q30 * 64'(k) + 64'(COS_TABLE_DEPTH / 2)) / 64'(COS_TABLE_DEPTH);
			cos_q30_tab[k] = taylor_cos(x);
		end
		cos_q30_tab[COS_TABLE_DEPTH] = 0;
		warmup_reg = 0;
		base_reg = 64'd4294967;
		floor_reg = 0;
		cycle_reg = 1;
		fail_count = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		rsp.ready = 1'b0;
		req.valid = 1'b0;
		req.epoch_number = '0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// defaults, then directed extremes
		add_epoch(0);
		add_epoch(32'hFFFF_FFFF);
		set_regs(10, 32'hFFFF_FFFF, 32'h1000_0000, 50);
		for (int e = 8; e < 13; e++) add_epoch(e);
		add_epoch(35);
		add_epoch(59);
		add_epoch(60);
		add_epoch(32'hFFFF_FFFF);
		add_epoch(32'h5555_5555);
		add_epoch(32'hAAAA_AAAA);
		set_regs(0, 0, 0, 0);
		add_epoch(0);
		add_epoch(7);
		set_regs(20, 1000, 5000, 8);
		for (int e = 19; e < 30; e++) add_epoch(e);
		set_regs(32'hFFFF, 32'h8000_0000, 0, 32'hFFFF);
		add_epoch(32'hFFFE);
		add_epoch(32'hFFFF);
		add_epoch(32'h1_0000);

		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 70; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 70; end
				3: begin send_idle_pct = 6; recv_stall_pct = 6; end
				default: ;
			endcase
			set_regs($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 40),
				$urandom_range(0, 5) == 0 ? $urandom_range(0, 3) : $urandom,
				$urandom_range(0, 3) == 0 ? $urandom : $urandom >> $urandom_range(0, 31),
				$urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 200));
			run_random(150);
		end
		drain();
		if (fail_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
hw/rtl/wcrf_pkg.sv
hw/rtl/wcrf_req_if.sv
hw/rtl/wcrf_rsp_if.sv
hw/rtl/wcrf_phase.sv
hw/rtl/wcrf_cos.sv
hw/rtl/wcrf_factor.sv
hw/rtl/warmup_cosine_restart_factor.sv
tb/sv/warmup_cosine_restart_factor_test.sv
